// File: design/lifo_stack_with_sort_unit_defines.svh
// Assertion macros shared by the stack modules.
// Both expect a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef LIFO_STACK_WITH_SORT_UNIT_DEFINES_SVH
`define LIFO_STACK_WITH_SORT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stack assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stack assertion failed");

`endif

// File: design/lss_pkg.sv
`default_nettype none

package lss_pkg;

  // Stack geometry.
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_SORT = 2'd3
  } cmd_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SORT = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;       // store the pushed value on top
    logic pop;        // remove the top entry
    logic read;       // return the top entry as the result value
    logic under;      // report underflow
    logic over;       // report overflow
    logic sort_step;  // run one compare-exchange pass
    logic sort_odd;   // pass works on odd pairs
    logic emit;       // issue a result next cycle
  } lss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } lss_status_t;

endpackage

`default_nettype wire

// File: design/lifo_stack_with_sort_unit.sv
// Bounded LIFO stack of sixteen 32-bit signed entries with an in-place sort.
// A request (cmd_i, push_value_i) is taken on a rising edge where start_i is
// high and busy_o is low. Push, pop and peek leave busy_o low, and a new
// request may follow in the very next cycle. Sort holds busy_o high while it
// runs one odd-even compare-exchange pass of the stored entries per cycle,
// which leaves the smallest value on top. Every request gives exactly one
// result, shown for a single cycle with done_o high, in the cycle after the
// request was taken (in the cycle after the last pass for sort). The receiver
// cannot stall: a result not captured while done_o is high is gone. Pop or peek
// on an empty stack flags underflow and returns zero; push on a full stack
// flags overflow and drops the value. entry_count_o and is_empty_o give the
// state after the request.
`default_nettype none

module lifo_stack_with_sort_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [1:0]            cmd_i,
  input  wire logic signed [31:0]    push_value_i,
  output logic                       done_o,
  output logic signed [31:0]         result_value_o,
  output logic                       is_empty_o,
  output logic [lss_pkg::CNT_W-1:0]  entry_count_o,
  output logic                       underflow_o,
  output logic                       overflow_o
);
  import lss_pkg::*;

  lss_cmd_t    dp_cmd;
  lss_status_t dp_status;

  // Sequencer for requests and sort passes.
  lss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .status_i (dp_status),
    .cmd_o    (dp_cmd),
    .busy_o   (busy_o)
  );

  // Stack store, fill count and result registers.
  lss_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .push_value_i   (push_value_i),
    .status_o       (dp_status),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .is_empty_o     (is_empty_o),
    .entry_count_o  (entry_count_o),
    .underflow_o    (underflow_o),
    .overflow_o     (overflow_o)
  );

endmodule

`default_nettype wire

// File: design/lss_ctrl.sv
`default_nettype none

`include "lifo_stack_with_sort_unit_defines.svh"

module lss_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [1:0]         cmd_i,
  input  lss_pkg::lss_status_t    status_i,
  output lss_pkg::lss_cmd_t       cmd_o,
  output logic                    busy_o
);
  import lss_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_PASS = ADDR_W'(DEPTH - 1);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] pass_q, pass_d;
  logic              accept;
  cmd_e              req_cmd;

  assign req_cmd = cmd_e'(cmd_i);
  assign accept  = start_i && (state_q == ST_IDLE);
  assign busy_o  = (state_q != ST_IDLE);

  // Next state and pass counter.
  always_comb begin
    state_d = state_q;
    pass_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_cmd == CMD_SORT)) begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        if (pass_q == LAST_PASS) begin
          state_d = ST_IDLE;
        end else begin
          pass_d = pass_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs to the datapath.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_cmd)
            CMD_PUSH: begin
              cmd_o.emit = 1'b1;
              cmd_o.push = !status_i.full;
              cmd_o.over = status_i.full;
            end
            CMD_POP: begin
              cmd_o.emit  = 1'b1;
              cmd_o.read  = !status_i.empty;
              cmd_o.pop   = !status_i.empty;
              cmd_o.under = status_i.empty;
            end
            CMD_PEEK: begin
              cmd_o.emit  = 1'b1;
              cmd_o.read  = !status_i.empty;
              cmd_o.under = status_i.empty;
            end
            CMD_SORT: cmd_o.emit = 1'b0;
            default:  cmd_o.emit = 1'b0;
          endcase
        end
      end
      ST_SORT: begin
        cmd_o.sort_step = 1'b1;
        cmd_o.sort_odd  = pass_q[0];
        cmd_o.emit      = (pass_q == LAST_PASS);
      end
      default: cmd_o = '0;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  // A sort request ends with exactly one result after all passes.
  `LSS_ASSERT_NEXT(a_sort_enters, accept && (req_cmd == CMD_SORT), state_q == ST_SORT)
  `LSS_ASSERT_NEXT(a_sort_length, accept && (req_cmd == CMD_SORT), ##(DEPTH - 1) cmd_o.emit)
  `LSS_ASSERT_NOW(a_no_mixed_ops, cmd_o.sort_step, !(cmd_o.push || cmd_o.pop || cmd_o.read))

endmodule

`default_nettype wire

// File: design/lss_datapath.sv
`default_nettype none

`include "lifo_stack_with_sort_unit_defines.svh"

module lss_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  lss_pkg::lss_cmd_t                cmd_i,
  input  wire logic signed [31:0]          push_value_i,
  output lss_pkg::lss_status_t             status_o,
  output logic                             done_o,
  output logic signed [31:0]               result_value_o,
  output logic                             is_empty_o,
  output logic [lss_pkg::CNT_W-1:0]        entry_count_o,
  output logic                             underflow_o,
  output logic                             overflow_o
);
  import lss_pkg::*;

  data_t             store_q [DEPTH];
  data_t             store_d [DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] top_idx;
  logic [DEPTH-2:0]  swap;
  data_t             value_q, value_d;
  logic              done_q, under_q, over_q;

  assign top_idx    = count_q[ADDR_W-1:0] - 1'b1;
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(DEPTH));

  // Odd-even transposition: each pair of the pass's parity within the fill swaps when the lower entry is smaller.
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      swap[i] = cmd_i.sort_step && (((i % 2) == 1) == cmd_i.sort_odd) &&
                (CNT_W'(i + 1) < count_q) && (store_q[i] < store_q[i + 1]);
    end
  end

  // Next contents of the stack store.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      store_d[j] = store_q[j];
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (swap[i]) begin
        store_d[i]     = store_q[i + 1];
        store_d[i + 1] = store_q[i];
      end
    end
    if (cmd_i.push) begin
      store_d[count_q[ADDR_W-1:0]] = push_value_i;
    end
  end

  // Fill count and result value.
  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
    end
    value_d = cmd_i.read ? store_q[top_idx] : '0;
  end

  // Store entries carry no reset; only entries below the fill count are read.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DEPTH; j++) begin
      store_q[j] <= store_d[j];
    end
    value_q <= value_d;
  end

  // Control and result flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
      under_q <= 1'b0;
      over_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.emit;
      under_q <= cmd_i.under;
      over_q  <= cmd_i.over;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = value_q;
  assign is_empty_o     = (count_q == '0);
  assign entry_count_o  = count_q;
  assign underflow_o    = under_q;
  assign overflow_o     = over_q;

  `LSS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
  `LSS_ASSERT_NOW(a_single_error, done_q, !(under_q && over_q))
  `LSS_ASSERT_NEXT(a_sort_keeps_count, cmd_i.sort_step, $stable(count_q))

endmodule

`default_nettype wire
